/* design/glse_pkg.sv */
// shared types, constants and helper functions for the lzw stream encoder
package glse_pkg;

    localparam int SYM_W      = 8;
    localparam int CFG_W      = 4;
    localparam int WIDTH_W    = 4;
    localparam int PUT_CODE_W = 13;
    localparam int BUF_W      = 24;
    localparam int CNT_W      = 5;
    localparam logic [CFG_W-1:0] ROOT_BITS_MIN   = 4'd2;
    localparam logic [CFG_W-1:0] ROOT_BITS_MAX   = 4'd8;
    localparam logic [CFG_W-1:0] ROOT_BITS_RESET = 4'd8;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_LOOK,
        ST_CMP,
        ST_MISS,
        ST_OVF,
        ST_EOS_PFX,
        ST_EOS_END,
        ST_FINISH
    } ctrl_state_t;

    // request from the controller to the bit packer
    typedef struct packed {
        logic                  put;
        logic [PUT_CODE_W-1:0] code;
        logic [WIDTH_W-1:0]    width;
        logic                  flush;
        logic                  finish;
        logic                  done;
    } pack_req_t;

    // saturate the root size register to its legal range
    function automatic logic [CFG_W-1:0] eff_bits(input logic [CFG_W-1:0] r);
        logic [CFG_W-1:0] b;
        b = r;
        if (b < ROOT_BITS_MIN)
        begin
            b = ROOT_BITS_MIN;
        end
        if (b > ROOT_BITS_MAX)
        begin
            b = ROOT_BITS_MAX;
        end
        return b;
    endfunction

    // ceil(log2(n)) for the code width
    function automatic logic [WIDTH_W-1:0] width_of(input logic [PUT_CODE_W-1:0] n);
        logic [WIDTH_W-1:0] w;
        w = '0;
        for (int i = 0; i < PUT_CODE_W; i++)
        begin
            if ((PUT_CODE_W'(1) << i) < n)
            begin
                w = WIDTH_W'(i + 1);
            end
        end
        return w;
    endfunction

endpackage

/* design/glse_dict.sv */
// hashed dictionary memory with a clearing sweep
module glse_dict import glse_pkg::*;
#(
    parameter int IDX_W  = 13,
    parameter int DATA_W = 33
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear_start,
    output logic              clearing,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [2**IDX_W];
    logic [DATA_W-1:0] rd_data_reg;
    logic              clr_reg;
    logic [IDX_W-1:0]  clr_addr_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    // sweep counter, runs after reset and on each clear request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clear_start)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg)
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    // write port shared by the sweep and the controller
    always_comb
    begin
        mem_we    = clr_reg || wr_en;
        mem_waddr = clr_reg ? clr_addr_reg : wr_addr;
        mem_wdata = clr_reg ? '0 : wr_data;
    end

    // storage, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_reg;

endmodule

/* design/glse_pack.sv */
// lsb-first code packer with a one-byte hold stage and output register
module glse_pack import glse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             init,
    input  pack_req_t        req,
    output logic             ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SYM_W-1:0] out_byte,
    output logic             stream_done,
    output logic             run_last
);

    logic [BUF_W-1:0] buf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             flush_reg;
    logic             fin_reg;
    logic             done_reg;
    logic             hold_valid_reg;
    logic [SYM_W-1:0] hold_byte_reg;
    logic             ov_reg;
    logic [SYM_W-1:0] ob_reg;
    logic             od_reg;
    logic             ol_reg;
    logic             draining;
    logic             out_free;
    logic             move;
    logic             fin_go;
    logic             load_out;
    logic [BUF_W-1:0] code_shifted;

    // drain and handshake conditions
    always_comb
    begin
        draining     = (cnt_reg >= CNT_W'(8)) || (flush_reg && (cnt_reg != '0));
        ready        = !draining && !fin_reg;
        out_free     = !ov_reg || out_ready;
        move         = draining && (!hold_valid_reg || out_free);
        fin_go       = fin_reg && (!hold_valid_reg || out_free);
        load_out     = !init && hold_valid_reg && (move || fin_go);
        code_shifted = BUF_W'(req.code) << cnt_reg[2:0];
    end

    // bit buffer, hold stage and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg        <= '0;
            cnt_reg        <= '0;
            flush_reg      <= 1'b0;
            fin_reg        <= 1'b0;
            done_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_byte_reg  <= '0;
            ov_reg         <= 1'b0;
            ob_reg         <= '0;
            od_reg         <= 1'b0;
            ol_reg         <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (init)
            begin
                buf_reg        <= '0;
                cnt_reg        <= '0;
                flush_reg      <= 1'b0;
                fin_reg        <= 1'b0;
                hold_valid_reg <= 1'b0;
            end
            else if (ready && req.put)
            begin
                buf_reg   <= buf_reg | code_shifted;
                cnt_reg   <= cnt_reg + CNT_W'(req.width);
                flush_reg <= req.flush;
            end
            else if (ready && req.finish)
            begin
                fin_reg  <= 1'b1;
                done_reg <= req.done;
            end
            else if (move)
            begin
                if (hold_valid_reg)
                begin
                    ob_reg <= hold_byte_reg;
                    ol_reg <= 1'b0;
                    od_reg <= 1'b0;
                end
                hold_valid_reg <= 1'b1;
                hold_byte_reg  <= buf_reg[SYM_W-1:0];
                buf_reg        <= buf_reg >> SYM_W;
                cnt_reg        <= (cnt_reg >= CNT_W'(8)) ? cnt_reg - CNT_W'(8) : '0;
            end
            else if (fin_go)
            begin
                if (hold_valid_reg)
                begin
                    ob_reg <= hold_byte_reg;
                    ol_reg <= 1'b1;
                    od_reg <= done_reg;
                end
                hold_valid_reg <= 1'b0;
                fin_reg        <= 1'b0;
            end
        end
    end

    assign out_valid   = ov_reg;
    assign out_byte    = ob_reg;
    assign stream_done = od_reg;
    assign run_last    = ol_reg;

endmodule

/* design/gif_lzw_stream_encoder.sv */
// gif lzw stream encoder top level: controller, dictionary and packer
// A symbol whose pair is found at the first probe passes through accept, start, read, compare
// and finish; each hash collision adds another memory read and compare, a miss adds the states
// that send the prefix code and check for overflow, end of stream adds the states that send
// the prefix and the end code, and every packed byte holds the controller while it drains,
// longer if the output is stalled. The dictionary is an open-addressed hash table of
// 2*DICT_ENTRIES entries in a memory with one write port and a registered read; its valid
// bits are wiped by a sweep over all 2*DICT_ENTRIES entries after reset, after a register
// write, after end of stream and after a dictionary reset, during which no new symbol is taken.
module gif_lzw_stream_encoder import glse_pkg::*;
#(
    parameter int MAX_CODE_BITS = 12,
    parameter int DICT_ENTRIES  = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [SYM_W-1:0] in_byte,
    input  logic             end_of_stream,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SYM_W-1:0] out_byte,
    output logic             stream_done,
    output logic             run_last
);

    localparam int IDX_W  = $clog2(DICT_ENTRIES) + 1;
    localparam int KEY_W  = MAX_CODE_BITS + SYM_W;
    localparam int NC_W   = MAX_CODE_BITS + 1;
    localparam int DATA_W = 1 + KEY_W + MAX_CODE_BITS;

    ctrl_state_t              state_reg;
    ctrl_state_t              state_next;
    logic [CFG_W-1:0]         root_bits_reg;
    logic [SYM_W-1:0]         sym_reg;
    logic                     eos_reg;
    logic [MAX_CODE_BITS-1:0] prefix_reg;
    logic                     prefix_valid_reg;
    logic [NC_W-1:0]          next_code_reg;
    logic [WIDTH_W-1:0]       width_reg;
    logic                     started_reg;
    logic [IDX_W-1:0]         probe_reg;

    logic [CFG_W-1:0]         eff;
    logic [CFG_W-1:0]         eff_init;
    logic [PUT_CODE_W-1:0]    root_code;
    logic [PUT_CODE_W-1:0]    init_code;
    logic [SYM_W-1:0]         sym_mask;
    logic [KEY_W-1:0]         key;
    logic [IDX_W-1:0]         hash;
    logic                     rd_valid;
    logic [KEY_W-1:0]         rd_key;
    logic [MAX_CODE_BITS-1:0] rd_code;
    logic [DATA_W-1:0]        rd_data;
    logic [DATA_W-1:0]        wr_data;
    logic                     clearing;
    logic                     clear_start;
    logic                     dict_rd;
    logic                     dict_wr;
    logic                     store_ok;
    logic [WIDTH_W-1:0]       new_width;
    logic                     ovf;
    logic                     hit;
    logic                     pack_ready;
    logic                     accept;
    pack_req_t                req;

    // root size, codes and lookup key
    always_comb
    begin
        eff       = eff_bits(root_bits_reg);
        eff_init  = eff_bits(cfg_we ? cfg_wdata : root_bits_reg);
        root_code = PUT_CODE_W'(1) << eff;
        init_code = (PUT_CODE_W'(1) << eff_init) + PUT_CODE_W'(2);
        sym_mask  = SYM_W'((9'd1 << eff) - 9'd1);
        key       = {prefix_reg, sym_reg};
        hash      = IDX_W'(key) ^ IDX_W'(key >> IDX_W);
        rd_valid  = rd_data[DATA_W-1];
        rd_key    = rd_data[DATA_W-2 -: KEY_W];
        rd_code   = rd_data[MAX_CODE_BITS-1:0];
        hit       = rd_valid && (rd_key == key);
        store_ok  = 32'(next_code_reg) < 32'(DICT_ENTRIES);
        new_width = width_of(PUT_CODE_W'(next_code_reg));
        ovf       = new_width > WIDTH_W'(MAX_CODE_BITS);
        wr_data   = {1'b1, key, MAX_CODE_BITS'(next_code_reg)};
        in_ready  = (state_reg == ST_IDLE) && !clearing;
        accept    = in_valid && in_ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (started_reg || pack_ready)
                begin
                    if (prefix_valid_reg)
                    begin
                        state_next = ST_LOOK;
                    end
                    else
                    begin
                        state_next = eos_reg ? ST_EOS_PFX : ST_FINISH;
                    end
                end
            end
            ST_LOOK:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (hit)
                begin
                    state_next = eos_reg ? ST_EOS_PFX : ST_FINISH;
                end
                else if (rd_valid)
                begin
                    state_next = ST_LOOK;
                end
                else
                begin
                    state_next = ST_MISS;
                end
            end
            ST_MISS:
            begin
                if (pack_ready)
                begin
                    state_next = ST_OVF;
                end
            end
            ST_OVF:
            begin
                if (!ovf || pack_ready)
                begin
                    state_next = eos_reg ? ST_EOS_PFX : ST_FINISH;
                end
            end
            ST_EOS_PFX:
            begin
                if (pack_ready)
                begin
                    state_next = ST_EOS_END;
                end
            end
            ST_EOS_END:
            begin
                if (pack_ready)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (pack_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb
    begin
        req         = '0;
        dict_rd     = 1'b0;
        dict_wr     = 1'b0;
        clear_start = cfg_we;
        case (state_reg)
            ST_START:
            begin
                if (!started_reg)
                begin
                    req.put   = 1'b1;
                    req.code  = root_code;
                    req.width = width_reg;
                end
            end
            ST_LOOK:
            begin
                dict_rd = 1'b1;
            end
            ST_MISS:
            begin
                req.put   = 1'b1;
                req.code  = PUT_CODE_W'(prefix_reg);
                req.width = width_reg;
                dict_wr   = pack_ready && store_ok;
            end
            ST_OVF:
            begin
                if (ovf)
                begin
                    req.put     = 1'b1;
                    req.code    = root_code;
                    req.width   = width_reg;
                    clear_start = cfg_we || pack_ready;
                end
            end
            ST_EOS_PFX:
            begin
                req.put   = 1'b1;
                req.code  = PUT_CODE_W'(prefix_reg);
                req.width = width_reg;
            end
            ST_EOS_END:
            begin
                req.put     = 1'b1;
                req.code    = root_code + PUT_CODE_W'(1);
                req.width   = width_reg;
                req.flush   = 1'b1;
                clear_start = cfg_we || pack_ready;
            end
            ST_FINISH:
            begin
                req.finish = 1'b1;
                req.done   = eos_reg;
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    // encoder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            root_bits_reg    <= ROOT_BITS_RESET;
            sym_reg          <= '0;
            eos_reg          <= 1'b0;
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            next_code_reg    <= NC_W'((PUT_CODE_W'(1) << ROOT_BITS_RESET) + PUT_CODE_W'(2));
            width_reg        <= width_of((PUT_CODE_W'(1) << ROOT_BITS_RESET) + PUT_CODE_W'(2));
            started_reg      <= 1'b0;
            probe_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                root_bits_reg    <= cfg_wdata;
                prefix_reg       <= '0;
                prefix_valid_reg <= 1'b0;
                next_code_reg    <= NC_W'(init_code);
                width_reg        <= width_of(init_code);
                started_reg      <= 1'b0;
            end
            else
            begin
                case (state_reg)
                    ST_IDLE:
                    begin
                        if (accept)
                        begin
                            sym_reg <= in_byte & sym_mask;
                            eos_reg <= end_of_stream;
                        end
                    end
                    ST_START:
                    begin
                        if (started_reg || pack_ready)
                        begin
                            started_reg <= 1'b1;
                            probe_reg   <= hash;
                            if (!prefix_valid_reg)
                            begin
                                prefix_reg       <= MAX_CODE_BITS'(sym_reg);
                                prefix_valid_reg <= 1'b1;
                            end
                        end
                    end
                    ST_CMP:
                    begin
                        if (hit)
                        begin
                            prefix_reg <= rd_code;
                        end
                        else if (rd_valid)
                        begin
                            probe_reg <= probe_reg + 1'b1;
                        end
                    end
                    ST_MISS:
                    begin
                        if (pack_ready)
                        begin
                            next_code_reg <= next_code_reg + 1'b1;
                        end
                    end
                    ST_OVF:
                    begin
                        if (!ovf)
                        begin
                            width_reg  <= new_width;
                            prefix_reg <= MAX_CODE_BITS'(sym_reg);
                        end
                        else if (pack_ready)
                        begin
                            next_code_reg <= NC_W'(root_code + PUT_CODE_W'(2));
                            width_reg     <= width_of(root_code + PUT_CODE_W'(2));
                            prefix_reg    <= MAX_CODE_BITS'(sym_reg);
                        end
                    end
                    ST_EOS_END:
                    begin
                        if (pack_ready)
                        begin
                            prefix_reg       <= '0;
                            prefix_valid_reg <= 1'b0;
                            next_code_reg    <= NC_W'(root_code + PUT_CODE_W'(2));
                            width_reg        <= width_of(root_code + PUT_CODE_W'(2));
                            started_reg      <= 1'b0;
                        end
                    end
                    default:
                    begin
                        started_reg <= started_reg;
                    end
                endcase
            end
        end
    end

    // dictionary hash table
    glse_dict #(
        .IDX_W  (IDX_W),
        .DATA_W (DATA_W)
    ) u_dict (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_start (clear_start),
        .clearing    (clearing),
        .rd_en       (dict_rd),
        .rd_addr     (probe_reg),
        .rd_data     (rd_data),
        .wr_en       (dict_wr),
        .wr_addr     (probe_reg),
        .wr_data     (wr_data)
    );

    // code packer and output stage
    glse_pack u_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .init        (cfg_we),
        .req         (req),
        .ready       (pack_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .stream_done (stream_done),
        .run_last    (run_last)
    );

endmodule
